[design/spacb_pkg.sv]
package spacb_pkg;

  localparam int Channels    = 4;
  localparam int ChanWidth   = $clog2(Channels);
  localparam int MapEntries  = 256;
  localparam int MapIdxWidth = $clog2(MapEntries);
  localparam int MapAddrWidth = ChanWidth + MapIdxWidth;
  localparam int AccWidth    = 18;
  localparam int ProdWidth   = 16;
  localparam int CountWidth  = 3;

  // floor(x / 100) = (x * RecipK) >> RecipShift for every 18-bit x
  localparam int RecipShift  = 25;
  localparam int RecipWidth  = 19;
  localparam logic [RecipWidth-1:0] RecipK = 19'd335545;
  localparam int QuotWidth   = AccWidth + RecipWidth;

  localparam logic OpData = 1'b0;
  localparam logic OpMap  = 1'b1;

  localparam logic [CountWidth-1:0] RegChannelCount = 3'd0;
  localparam logic [CountWidth-1:0] RegWeightCh0    = 3'd1;
  localparam logic [CountWidth-1:0] RegWeightCh1    = 3'd2;
  localparam logic [CountWidth-1:0] RegWeightCh2    = 3'd3;
  localparam logic [CountWidth-1:0] RegWeightCh3    = 3'd4;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cmap_entry_t;

endpackage

[design/scan_pixel_average_colormap_blend.sv]
// Channel   | Direction | Handshake           | Beat contents
// in        | input     | in_valid/in_ready   | opcode, sample_a..d, map_* fields
// out       | output    | out_valid/out_ready | average, channel_index, color_valid, RGB
// cfg       | input     | cfg_write           | cfg_index, cfg_data
//
// One beat per cycle in steady state while the output is not stalled; a data beat passes
// through colormap read, weight multiply, accumulate, reciprocal multiply and output register.
// Map-write beats are written to the colormap when accepted and produce no output beat.
// Reset (rst, synchronous) clears pipeline valids, channel position and accumulators, and sets
// the configuration registers to their defaults; colormap contents are undefined until written.
// A stalled output lets the pipeline fill its empty stages before in_ready drops.
module scan_pixel_average_colormap_blend (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [15:0] sample_a,
  input  logic [15:0] sample_b,
  input  logic [15:0] sample_c,
  input  logic [15:0] sample_d,
  input  logic [1:0]  map_channel,
  input  logic [7:0]  map_index,
  input  logic [7:0]  map_red,
  input  logic [7:0]  map_green,
  input  logic [7:0]  map_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] average,
  output logic [1:0]  channel_index,
  output logic        color_valid,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import spacb_pkg::*;

  // configuration
  logic [CountWidth-1:0] channel_count;
  logic [7:0]            weight [Channels];

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= 3'd1;
      weight[0]     <= 8'd100;
      weight[1]     <= 8'd0;
      weight[2]     <= 8'd0;
      weight[3]     <= 8'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        RegChannelCount: channel_count <= cfg_data[CountWidth-1:0];
        RegWeightCh0:    weight[0] <= cfg_data;
        RegWeightCh1:    weight[1] <= cfg_data;
        RegWeightCh2:    weight[2] <= cfg_data;
        RegWeightCh3:    weight[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [CountWidth-1:0] count_eff;
  always_comb begin
    count_eff = channel_count;
    if (channel_count == '0) count_eff = 3'd1;
    if (channel_count > CountWidth'(Channels)) count_eff = CountWidth'(Channels);
  end

  // stage enables, chained back from the output register
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, adv_out;

  assign adv_out  = !out_valid || out_ready;
  assign en4      = !v4 || adv_out;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  logic acc_in, take_data, take_map;
  assign acc_in    = in_valid && in_ready;
  assign take_data = acc_in && (opcode == OpData);
  assign take_map  = acc_in && (opcode == OpMap);

  // stage 0: average, position, colormap address
  logic [ChanWidth-1:0] position;
  logic [17:0]          sum;
  logic [15:0]          avg;
  logic                 last_in;

  assign sum = {2'b00, sample_a} + {2'b00, sample_b} + {2'b00, sample_c} + {2'b00, sample_d};
  assign avg = sum[17:2];
  assign last_in = ({1'b0, position} + 3'd1) >= count_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (take_data) begin
      position <= last_in ? '0 : position + 1'b1;
    end
  end

  cmap_entry_t map_wdata, map_rdata;
  assign map_wdata = '{red: map_red, green: map_green, blue: map_blue};

  spacb_cmap_ram u_cmap (
    .clk     (clk),
    .wr_en   (take_map),
    .wr_addr ({map_channel, map_index}),
    .wr_data (map_wdata),
    .rd_en   (take_data),
    .rd_addr ({position, ~avg[15:8]}),
    .rd_data (map_rdata)
  );

  // stage 1: colormap data arrives
  logic [15:0]          s1_avg;
  logic [ChanWidth-1:0] s1_ch;
  logic                 s1_last;
  logic [7:0]           s1_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= take_data;
    end
  end

  always_ff @(posedge clk) begin
    if (take_data) begin
      s1_avg    <= avg;
      s1_ch     <= position;
      s1_last   <= last_in;
      s1_weight <= weight[position];
    end
  end

  // stage 2: weight times component
  logic [15:0]          s2_avg;
  logic [ChanWidth-1:0] s2_ch;
  logic                 s2_last;
  logic [ProdWidth-1:0] s2_pr, s2_pg, s2_pb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      s2_avg  <= s1_avg;
      s2_ch   <= s1_ch;
      s2_last <= s1_last;
      s2_pr   <= s1_weight * map_rdata.red;
      s2_pg   <= s1_weight * map_rdata.green;
      s2_pb   <= s1_weight * map_rdata.blue;
    end
  end

  // stage 3: accumulate, hand the total on at the last channel
  logic [AccWidth-1:0]  acc_r, acc_g, acc_b;
  logic [AccWidth-1:0]  sum_r, sum_g, sum_b;
  logic [15:0]          s3_avg;
  logic [ChanWidth-1:0] s3_ch;
  logic                 s3_last;
  logic [AccWidth-1:0]  s3_tr, s3_tg, s3_tb;
  logic                 step3;

  assign step3 = en3 && v2;
  assign sum_r = acc_r + AccWidth'(s2_pr);
  assign sum_g = acc_g + AccWidth'(s2_pg);
  assign sum_b = acc_b + AccWidth'(s2_pb);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3    <= 1'b0;
      acc_r <= '0;
      acc_g <= '0;
      acc_b <= '0;
    end else begin
      if (en3) v3 <= v2;
      if (step3) begin
        acc_r <= s2_last ? '0 : sum_r;
        acc_g <= s2_last ? '0 : sum_g;
        acc_b <= s2_last ? '0 : sum_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step3) begin
      s3_avg  <= s2_avg;
      s3_ch   <= s2_ch;
      s3_last <= s2_last;
      s3_tr   <= s2_last ? sum_r : '0;
      s3_tg   <= s2_last ? sum_g : '0;
      s3_tb   <= s2_last ? sum_b : '0;
    end
  end

  // stage 4: multiply by the reciprocal of 100
  logic [15:0]          s4_avg;
  logic [ChanWidth-1:0] s4_ch;
  logic                 s4_last;
  logic [QuotWidth-1:0] s4_qr, s4_qg, s4_qb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      s4_avg  <= s3_avg;
      s4_ch   <= s3_ch;
      s4_last <= s3_last;
      s4_qr   <= QuotWidth'(s3_tr) * QuotWidth'(RecipK);
      s4_qg   <= QuotWidth'(s3_tg) * QuotWidth'(RecipK);
      s4_qb   <= QuotWidth'(s3_tb) * QuotWidth'(RecipK);
    end
  end

  // output register: keep the low byte of the quotient
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && v4) begin
      average       <= s4_avg;
      channel_index <= s4_ch;
      color_valid   <= s4_last;
      red           <= s4_qr[RecipShift +: 8];
      green         <= s4_qg[RecipShift +: 8];
      blue          <= s4_qb[RecipShift +: 8];
    end
  end

endmodule

[design/spacb_cmap_ram.sv]
module spacb_cmap_ram (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [spacb_pkg::MapAddrWidth-1:0]  wr_addr,
  input  spacb_pkg::cmap_entry_t              wr_data,
  input  logic                                rd_en,
  input  logic [spacb_pkg::MapAddrWidth-1:0]  rd_addr,
  output spacb_pkg::cmap_entry_t              rd_data
);
  import spacb_pkg::*;

  cmap_entry_t mem [Channels*MapEntries];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data while the stage behind is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
  import spacb_pkg::*;

  typedef struct packed {
    logic              opcode;
    logic [3:0][15:0]  samples;
    logic [1:0]        map_channel;
    logic [7:0]        map_index;
    cmap_entry_t       color;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] average;
    logic [1:0]  channel_index;
    logic        color_valid;
    cmap_entry_t color;
  } out_beat_t;

  localparam int IdleLimit    = 3000;
  localparam int SettleCycles = 8;
  localparam int PhaseBeats   = 160;
  localparam int Phases       = 8;
  localparam logic [2:0] RegTop = 3'd7;

  class pixel_blend_model;
    logic [2:0]          count_reg;
    logic [7:0]          weight [Channels];
    cmap_entry_t         colormap [Channels*MapEntries];
    bit                  written [Channels*MapEntries];
    logic [1:0]          position;
    logic [AccWidth-1:0] acc [3];
    out_beat_t           pending_pixels [$];
    int                  errors;

    function new();
      count_reg = 3'd1;
      weight[0] = 8'd100;
      weight[1] = 8'd0;
      weight[2] = 8'd0;
      weight[3] = 8'd0;
      position = '0;
      for (int m = 0; m < 3; m++) acc[m] = '0;
      for (int i = 0; i < Channels*MapEntries; i++) begin
        colormap[i] = '0;
        written[i] = 1'b0;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] data);
      case (idx)
        RegChannelCount: count_reg = data[2:0];
        RegWeightCh0:    weight[0] = data;
        RegWeightCh1:    weight[1] = data;
        RegWeightCh2:    weight[2] = data;
        RegWeightCh3:    weight[3] = data;
        default: ;
      endcase
    endfunction

    function void accept_beat(in_beat_t b);
      logic [17:0] total;
      logic [15:0] avg;
      logic [1:0]  ch;
      logic [2:0]  active;
      cmap_entry_t hit;
      out_beat_t   px;
      if (b.opcode == OpMap) begin
        colormap[int'({b.map_channel, b.map_index})] = b.color;
        written[int'({b.map_channel, b.map_index})] = 1'b1;
        return;
      end
      ch = position;
      total = 18'(b.samples[0]) + 18'(b.samples[1]) + 18'(b.samples[2]) + 18'(b.samples[3]);
      avg = total[17:2];
      // entry address counts down from the top of the map as the average rises
      hit = colormap[int'({ch, 8'd255 - avg[15:8]})];
      acc[0] = acc[0] + weight[ch] * hit.red;
      acc[1] = acc[1] + weight[ch] * hit.green;
      acc[2] = acc[2] + weight[ch] * hit.blue;
      if (count_reg == 3'd0) active = 3'd1;
      else if (count_reg > 3'(Channels)) active = 3'(Channels);
      else active = count_reg;
      px.average = avg;
      px.channel_index = ch;
      px.color_valid = ((3'(ch) + 3'd1) >= active);
      if (px.color_valid) begin
        px.color.red   = 8'(acc[0] / 100);
        px.color.green = 8'(acc[1] / 100);
        px.color.blue  = 8'(acc[2] / 100);
        for (int m = 0; m < 3; m++) acc[m] = '0;
        position = '0;
      end else begin
        px.color = '0;
        position = ch + 2'd1;
      end
      pending_pixels.push_back(px);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_pixel(out_beat_t got);
      out_beat_t want;
      if (pending_pixels.size() == 0) begin
        report($sformatf("output beat with nothing pending, average %0d", got.average));
        return;
      end
      want = pending_pixels.pop_front();
      if (got.average !== want.average)
        report($sformatf("average %0d, want %0d", got.average, want.average));
      if (got.channel_index !== want.channel_index)
        report($sformatf("channel_index %0d, want %0d", got.channel_index, want.channel_index));
      if (got.color_valid !== want.color_valid)
        report($sformatf("color_valid %0b, want %0b", got.color_valid, want.color_valid));
      if (got.color.red !== want.color.red)
        report($sformatf("red %0d, want %0d", got.color.red, want.color.red));
      if (got.color.green !== want.color.green)
        report($sformatf("green %0d, want %0d", got.color.green, want.color.green));
      if (got.color.blue !== want.color.blue)
        report($sformatf("blue %0d, want %0d", got.color.blue, want.color.blue));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        opcode = OpData;
  logic [15:0] sample_a = '0;
  logic [15:0] sample_b = '0;
  logic [15:0] sample_c = '0;
  logic [15:0] sample_d = '0;
  logic [1:0]  map_channel = '0;
  logic [7:0]  map_index = '0;
  logic [7:0]  map_red = '0;
  logic [7:0]  map_green = '0;
  logic [7:0]  map_blue = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] average;
  logic [1:0]  channel_index;
  logic        color_valid;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int beats_sent = 0;
  int idle_cycles = 0;

  pixel_blend_model blend = new();

  scan_pixel_average_colormap_blend i_dut (.*);

  initial forever #2 clk = ~clk;

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      blend.check_pixel({average, channel_index, color_valid, red, green, blue});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout: no beat moved for %0d cycles", IdleLimit);
      $display("** scan_pixel_average_colormap_blend: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_beat(input in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= b.opcode;
    sample_a    <= b.samples[0];
    sample_b    <= b.samples[1];
    sample_c    <= b.samples[2];
    sample_d    <= b.samples[3];
    map_channel <= b.map_channel;
    map_index   <= b.map_index;
    map_red     <= b.color.red;
    map_green   <= b.color.green;
    map_blue    <= b.color.blue;
    do @(posedge clk); while (!in_ready);
    blend.accept_beat(b);
    beats_sent++;
  endtask

  // drop valid and wait for every pending pixel, then let the pipeline empty
  task automatic settle(input int extra);
    in_valid <= 1'b0;
    while (blend.pending_pixels.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic configure(input logic [2:0] count, input logic [7:0] w0, w1, w2, w3);
    logic [2:0] regs [5];
    logic [7:0] vals [5];
    logic [7:0] junk;
    regs = '{RegChannelCount, RegWeightCh0, RegWeightCh1, RegWeightCh2, RegWeightCh3};
    vals = '{{5'($urandom), count}, w0, w1, w2, w3};
    // stray indexes must leave every register alone
    for (int i = int'(RegWeightCh3) + 1; i <= int'(RegTop); i++) begin
      junk = 8'($urandom);
      cfg_write <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= junk;
      @(posedge clk);
      blend.write_reg(3'(i), junk);
    end
    for (int i = 0; i < 5; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      blend.write_reg(regs[i], vals[i]);
    end
    cfg_write <= 1'b0;
  endtask

  function automatic in_beat_t junk_beat();
    logic [127:0] r;
    r = {$urandom(), $urandom(), $urandom(), $urandom()};
    return r[$bits(in_beat_t)-1:0];
  endfunction

  function automatic in_beat_t map_beat(input logic [1:0] ch, input logic [7:0] idx,
                                        input cmap_entry_t c);
    in_beat_t b;
    b = junk_beat();
    b.opcode = OpMap;
    b.map_channel = ch;
    b.map_index = idx;
    b.color = c;
    return b;
  endfunction

  function automatic in_beat_t data_beat(input logic [3:0][15:0] s);
    in_beat_t b;
    b = junk_beat();
    b.opcode = OpData;
    b.samples = s;
    return b;
  endfunction

  function automatic cmap_entry_t rand_color();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return cmap_entry_t'(24'($urandom));
    endcase
  endfunction

  function automatic logic [7:0] rand_weight();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd100;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [3:0][15:0] rand_samples();
    logic [3:0][15:0] s;
    case ($urandom_range(0, 9))
      0: s = '0;
      1: s = '1;
      2: for (int i = 0; i < 4; i++) s[i] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: for (int i = 0; i < 4; i++) s[i] = 16'($urandom);
    endcase
    return s;
  endfunction

  // load the entry this beat will hit first if nothing has been stored there yet
  task automatic send_channel(input logic [3:0][15:0] s);
    logic [17:0] total;
    logic [7:0]  idx;
    logic [1:0]  ch;
    total = 18'(s[0]) + 18'(s[1]) + 18'(s[2]) + 18'(s[3]);
    idx = 8'd255 - total[17:10];
    ch = blend.position;
    if (!blend.written[int'({ch, idx})]) send_beat(map_beat(ch, idx, rand_color()));
    send_beat(data_beat(s));
  endtask

  initial begin
    int idle_by_phase [4];
    int stall_by_phase [4];
    logic [2:0] count_by_phase [Phases];
    int goal;
    int midpoint;
    bit paused;
    idle_by_phase  = '{0, 71, 0, 6};
    stall_by_phase = '{0, 0, 71, 6};
    count_by_phase = '{3'd4, 3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd7, 3'd4};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: one channel at full weight
    send_beat(map_beat(2'd0, 8'd255, '1));
    send_beat(data_beat('0));
    send_beat(map_beat(2'd0, 8'd0, cmap_entry_t'(24'h010203)));
    send_beat(data_beat('1));
    send_beat(data_beat({16'hFFFC, 16'hFFFF, 16'hFFFF, 16'hFFFF}));
    settle(SettleCycles);

    // four channels at maximum weight wrap the 8-bit colour
    configure(3'd4, 8'd255, 8'd255, 8'd255, 8'd255);
    send_beat(map_beat(2'd1, 8'd255, '1));
    send_beat(map_beat(2'd2, 8'd255, '1));
    send_beat(map_beat(2'd3, 8'd255, '1));
    repeat (4) send_beat(data_beat('0));
    // stop three channels into a pixel, then lower the count under the position
    repeat (3) send_beat(data_beat('0));
    settle(SettleCycles);
    configure(3'd2, 8'd0, 8'd255, 8'd1, 8'd100);
    send_beat(data_beat('0));
    settle(SettleCycles);

    configure(3'd0, 8'd100, 8'd50, 8'd255, 8'd0);
    repeat (2) send_beat(data_beat('0));
    settle(SettleCycles);
    configure(3'd7, 8'd100, 8'd100, 8'd100, 8'd100);
    repeat (4) send_channel(rand_samples());

    for (int p = 0; p < Phases; p++) begin
      settle(SettleCycles);
      send_idle_pct = idle_by_phase[p % 4];
      stall_pct = stall_by_phase[p % 4];
      if (p == 1) configure(count_by_phase[p], 8'd255, 8'd255, 8'd255, 8'd255);
      else if (p == 2) configure(count_by_phase[p], 8'd0, 8'd0, 8'd0, 8'd0);
      else configure(count_by_phase[p], rand_weight(), rand_weight(), rand_weight(),
                     rand_weight());
      goal = beats_sent + PhaseBeats;
      midpoint = beats_sent + PhaseBeats / 2;
      paused = 1'b0;
      while (beats_sent < goal) begin
        if (!paused && beats_sent >= midpoint) begin
          settle(0);
          paused = 1'b1;
        end
        if ($urandom_range(0, 6) == 0)
          send_beat(map_beat(2'($urandom), 8'($urandom), rand_color()));
        else
          send_channel(rand_samples());
      end
    end

    settle(SettleCycles + 2);
    if (blend.errors == 0 && blend.pending_pixels.size() == 0) begin
      $display("** scan_pixel_average_colormap_blend: PASSED **");
    end else begin
      $display("** scan_pixel_average_colormap_blend: FAILED **");
    end
    $finish;
  end

endmodule
